/* design/window_frequency_victim_select_assert.svh */
// Assertion macros shared by the window victim selector.
`ifndef WINDOW_FREQUENCY_VICTIM_SELECT_ASSERT_SVH
`define WINDOW_FREQUENCY_VICTIM_SELECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFVS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/wfvs_pkg.sv */
package wfvs_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int NUM_SEGMENTS = 64;

    localparam int OP_W   = 2;
    localparam int SEG_W  = 6;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 7;
    localparam int RING_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SIDX_W = $clog2(NUM_SEGMENTS);
    localparam int SCAN_W = $clog2(NUM_SEGMENTS + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd16;

    localparam logic [OP_W-1:0] OP_REFERENCE = 2'd0;
    localparam logic [OP_W-1:0] OP_RESIDENCY = 2'd1;
    localparam logic [OP_W-1:0] OP_FORGET    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SEG_W-1:0] segment_id;
        logic             resident;
    } in_word_t;

    typedef struct packed {
        logic [SEG_W-1:0] victim_id;
        logic             victim_valid;
        logic             victim_is_resident;
        logic [CNT_W-1:0] victim_count;
    } out_word_t;

endpackage

/* design/wfvs_if.sv */
interface wfvs_in_if;
    import wfvs_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wfvs_out_if;
    import wfvs_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wfvs_cfg_if;
    import wfvs_pkg::*;

    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/window_frequency_victim_select.sv */
// Window frequency victim selector. Each input word (reference, residency update or
// forget of a segment) updates the reference window, per-segment counts or residency
// flags, and then one result word names the eviction victim. Its result is registered
// in the output register when that is free; while an earlier result still waits in
// the output register, the new result waits for it. The next word is accepted in the
// cycle after the result is registered, even if it has not been taken yet. The time
// a word takes is set by the victim search, which reads the per-segment count memory
// one entry per cycle, and by the forget, which compacts the window memory one entry
// per cycle. Counts and residency flags read as zero until first written, so no
// clearing pass follows reset. The window length register may be written at any
// time the block is idle.
`include "window_frequency_victim_select_assert.svh"

module window_frequency_victim_select (
    input  logic        clk,
    input  logic        rst_n,
    wfvs_in_if.sink     req,
    wfvs_out_if.source  rsp,
    wfvs_cfg_if.sink    cfg
);
    import wfvs_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INC_RD    = 4'd1;
    localparam logic [3:0] S_INC_WR    = 4'd2;
    localparam logic [3:0] S_DROP_CHK  = 4'd3;
    localparam logic [3:0] S_DROP_SEG  = 4'd4;
    localparam logic [3:0] S_DROP_WR   = 4'd5;
    localparam logic [3:0] S_FGT       = 4'd6;
    localparam logic [3:0] S_SCAN_INIT = 4'd7;
    localparam logic [3:0] S_SCAN      = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(WINDOW_DEPTH);
    localparam logic [SCAN_W-1:0] NSEG_S  = SCAN_W'(NUM_SEGMENTS);

    function automatic logic [RING_W-1:0] ring_index(input logic [RING_W-1:0] base,
                                                     input logic [FILL_W-1:0] off);
        logic [FILL_W:0] sum;
        sum = (FILL_W + 1)'(base) + (FILL_W + 1)'(off);
        if (sum >= (FILL_W + 1)'(WINDOW_DEPTH))
        begin
            sum = sum - (FILL_W + 1)'(WINDOW_DEPTH);
        end
        return RING_W'(sum);
    endfunction

    logic [SEG_W-1:0]  ring_mem [WINDOW_DEPTH];
    logic [CNT_W-1:0]  cnt_mem [NUM_SEGMENTS];
    logic              res_mem [NUM_SEGMENTS];

    logic [3:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg;
    logic [SIDX_W-1:0] seg_reg, seg_next;
    logic [SEG_W-1:0]  segid_reg, segid_next;
    logic [RING_W-1:0] head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] r_reg, r_next;
    logic [FILL_W-1:0] kept_reg, kept_next;
    logic [SCAN_W-1:0] s_reg, s_next;
    logic              pend_reg, pend_next;
    logic              found_any_reg, found_any_next;
    logic              found_res_reg, found_res_next;
    logic [SIDX_W-1:0] any_id_reg, any_id_next;
    logic [CNT_W-1:0]  any_cnt_reg, any_cnt_next;
    logic [SIDX_W-1:0] res_id_reg, res_id_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_data_reg, out_data_next;

    logic [NUM_SEGMENTS-1:0] cnt_vld_reg;
    logic [NUM_SEGMENTS-1:0] res_vld_reg;
    logic              cnt_vq_reg;
    logic              res_vq_reg;
    logic [SEG_W-1:0]  ring_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;
    logic              res_rd_reg;
    logic [SIDX_W-1:0] scan_addr_reg;

    logic              ring_we, ring_re;
    logic [RING_W-1:0] ring_waddr, ring_raddr;
    logic [SEG_W-1:0]  ring_wdata;
    logic              cnt_we, cnt_re;
    logic [SIDX_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              res_we, res_re;
    logic [SIDX_W-1:0] res_waddr, res_raddr;

    logic [FILL_W-1:0] eff_len;
    logic [CNT_W-1:0]  cnt_val;
    logic              res_val;
    logic              req_seg_ok;
    logic              drop_seg_ok;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign cnt_val     = cnt_vq_reg ? cnt_rd_reg : '0;
    assign res_val     = res_vq_reg & res_rd_reg;
    assign req_seg_ok  = int'(req.data.segment_id) < NUM_SEGMENTS;
    assign drop_seg_ok = int'(ring_rd_reg) < NUM_SEGMENTS;

    always_comb
    begin
        if (len_reg < LEN_W'(2))
        begin
            eff_len = FILL_W'(2);
        end
        else if (int'(len_reg) > WINDOW_DEPTH)
        begin
            eff_len = DEPTH_F;
        end
        else
        begin
            eff_len = FILL_W'(len_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        segid_next     = segid_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        r_next         = r_reg;
        kept_next      = kept_reg;
        s_next         = s_reg;
        pend_next      = pend_reg;
        found_any_next = found_any_reg;
        found_res_next = found_res_reg;
        any_id_next    = any_id_reg;
        any_cnt_next   = any_cnt_reg;
        res_id_next    = res_id_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        out_data_next  = out_data_reg;

        ring_we    = 1'b0;
        ring_waddr = '0;
        ring_wdata = '0;
        ring_re    = 1'b0;
        ring_raddr = '0;
        cnt_we     = 1'b0;
        cnt_waddr  = seg_reg;
        cnt_wdata  = '0;
        cnt_re     = 1'b0;
        cnt_raddr  = seg_reg;
        res_we     = 1'b0;
        res_waddr  = SIDX_W'(req.data.segment_id);
        res_re     = 1'b0;
        res_raddr  = SIDX_W'(s_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    seg_next   = SIDX_W'(req.data.segment_id);
                    segid_next = req.data.segment_id;
                    state_next = S_SCAN_INIT;
                    if (req_seg_ok)
                    begin
                        case (req.data.op)
                            OP_REFERENCE:
                            begin
                                state_next = (fill_reg < DEPTH_F) ? S_INC_RD : S_DROP_CHK;
                            end
                            OP_RESIDENCY:
                            begin
                                res_we = 1'b1;
                            end
                            OP_FORGET:
                            begin
                                r_next     = '0;
                                kept_next  = '0;
                                pend_next  = 1'b0;
                                state_next = S_FGT;
                            end
                            default:
                            begin
                                state_next = S_SCAN_INIT;
                            end
                        endcase
                    end
                end
            end

            S_INC_RD:
            begin
                ring_we    = 1'b1;
                ring_waddr = ring_index(head_reg, fill_reg);
                ring_wdata = segid_reg;
                cnt_re     = 1'b1;
                cnt_raddr  = seg_reg;
                fill_next  = fill_reg + FILL_W'(1);
                state_next = S_INC_WR;
            end

            S_INC_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = seg_reg;
                cnt_wdata  = (cnt_val < COUNT_MAX) ? cnt_val + CNT_W'(1) : cnt_val;
                state_next = S_DROP_CHK;
            end

            S_DROP_CHK:
            begin
                if (fill_reg != '0 && fill_reg >= eff_len)
                begin
                    ring_re    = 1'b1;
                    ring_raddr = head_reg;
                    state_next = S_DROP_SEG;
                end
                else
                begin
                    state_next = S_SCAN_INIT;
                end
            end

            S_DROP_SEG:
            begin
                head_next = ring_index(head_reg, FILL_W'(1));
                fill_next = fill_reg - FILL_W'(1);
                if (drop_seg_ok)
                begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = SIDX_W'(ring_rd_reg);
                    state_next = S_DROP_WR;
                end
                else
                begin
                    state_next = S_SCAN_INIT;
                end
            end

            S_DROP_WR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = SIDX_W'(ring_rd_reg);
                cnt_wdata  = (cnt_val != '0) ? cnt_val - CNT_W'(1) : cnt_val;
                state_next = S_SCAN_INIT;
            end

            S_FGT:
            begin
                if (pend_reg && ring_rd_reg != segid_reg)
                begin
                    ring_we    = 1'b1;
                    ring_waddr = ring_index(head_reg, kept_reg);
                    ring_wdata = ring_rd_reg;
                    kept_next  = kept_reg + FILL_W'(1);
                end
                if (r_reg < fill_reg)
                begin
                    ring_re    = 1'b1;
                    ring_raddr = ring_index(head_reg, r_reg);
                    r_next     = r_reg + FILL_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fill_next  = kept_reg;
                        cnt_we     = 1'b1;
                        cnt_waddr  = seg_reg;
                        cnt_wdata  = '0;
                        state_next = S_SCAN_INIT;
                    end
                end
            end

            S_SCAN_INIT:
            begin
                s_next         = '0;
                pend_next      = 1'b0;
                found_any_next = 1'b0;
                found_res_next = 1'b0;
                any_id_next    = '0;
                any_cnt_next   = '0;
                res_id_next    = '0;
                res_cnt_next   = '0;
                state_next     = S_SCAN;
            end

            S_SCAN:
            begin
                if (pend_reg && cnt_val != '0)
                begin
                    if (!found_any_reg)
                    begin
                        found_any_next = 1'b1;
                        any_id_next    = scan_addr_reg;
                        any_cnt_next   = cnt_val;
                    end
                    if (res_val && (!found_res_reg || cnt_val < res_cnt_reg))
                    begin
                        found_res_next = 1'b1;
                        res_id_next    = scan_addr_reg;
                        res_cnt_next   = cnt_val;
                    end
                end
                if (s_reg < NSEG_S)
                begin
                    cnt_re    = 1'b1;
                    cnt_raddr = SIDX_W'(s_reg);
                    res_re    = 1'b1;
                    res_raddr = SIDX_W'(s_reg);
                    s_next    = s_reg + SCAN_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    if (found_res_reg)
                    begin
                        out_data_next.victim_id          = SEG_W'(res_id_reg);
                        out_data_next.victim_valid       = 1'b1;
                        out_data_next.victim_is_resident = 1'b1;
                        out_data_next.victim_count       = res_cnt_reg;
                    end
                    else if (found_any_reg)
                    begin
                        out_data_next.victim_id          = SEG_W'(any_id_reg);
                        out_data_next.victim_valid       = 1'b1;
                        out_data_next.victim_is_resident = 1'b0;
                        out_data_next.victim_count       = any_cnt_reg;
                    end
                    else
                    begin
                        out_data_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= LEN_RESET;
            seg_reg       <= '0;
            segid_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            r_reg         <= '0;
            kept_reg      <= '0;
            s_reg         <= '0;
            pend_reg      <= 1'b0;
            found_any_reg <= 1'b0;
            found_res_reg <= 1'b0;
            any_id_reg    <= '0;
            any_cnt_reg   <= '0;
            res_id_reg    <= '0;
            res_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            cnt_vld_reg   <= '0;
            res_vld_reg   <= '0;
            cnt_vq_reg    <= 1'b0;
            res_vq_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            segid_reg     <= segid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            r_reg         <= r_next;
            kept_reg      <= kept_next;
            s_reg         <= s_next;
            pend_reg      <= pend_next;
            found_any_reg <= found_any_next;
            found_res_reg <= found_res_next;
            any_id_reg    <= any_id_next;
            any_cnt_reg   <= any_cnt_next;
            res_id_reg    <= res_id_next;
            res_cnt_reg   <= res_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                len_reg <= cfg.data;
            end
            if (cnt_we)
            begin
                cnt_vld_reg[cnt_waddr] <= 1'b1;
            end
            if (res_we)
            begin
                res_vld_reg[res_waddr] <= 1'b1;
            end
            if (cnt_re)
            begin
                cnt_vq_reg <= cnt_vld_reg[cnt_raddr];
            end
            if (res_re)
            begin
                res_vq_reg <= res_vld_reg[res_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg    <= cnt_mem[cnt_raddr];
            scan_addr_reg <= cnt_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_waddr] <= req.data.resident;
        end
        if (res_re)
        begin
            res_rd_reg <= res_mem[res_raddr];
        end
    end

    // The window never holds more entries than its memory has rows.
    `WFVS_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= DEPTH_F, "window fill exceeds depth")
    `WFVS_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
        "input accepted again before the search finished")
    `WFVS_ASSERT_SAME(a_empty_result, rsp.valid && !rsp.data.victim_valid,
        rsp.data.victim_id == '0 && rsp.data.victim_count == '0 &&
        !rsp.data.victim_is_resident, "empty result carries nonzero fields")
    `WFVS_ASSERT_SAME(a_count_matches_valid, rsp.valid,
        rsp.data.victim_valid == (rsp.data.victim_count != '0),
        "victim count disagrees with victim valid")
    // A free output register is loaded as soon as the search is done.
    `WFVS_ASSERT_NEXT(a_result_loaded, state_reg == S_DONE && !out_valid_reg,
        out_valid_reg && state_reg == S_IDLE, "finished result was not registered")

endmodule

/* test/tb_top.sv */
module tb_top;
    import wfvs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int WORDS_PER_PHASE = 72;
    localparam int NUM_PHASES = 7;

    logic clk;
    logic rst_n = 1'b0;

    wfvs_in_if  req_if ();
    wfvs_out_if rsp_if ();
    wfvs_cfg_if cfg_if ();

    window_frequency_victim_select u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    in_word_t  words_to_send[$];
    out_word_t victims_due[$];

    logic [SEG_W-1:0] ring_ids[WINDOW_DEPTH];
    int               ring_head = 0;
    int               ring_fill = 0;
    logic [CNT_W-1:0] seg_counts[NUM_SEGMENTS] = '{default: '0};
    bit               seg_resident[NUM_SEGMENTS] = '{default: 1'b0};
    logic [LEN_W-1:0] window_len = LEN_RESET;

    int mismatches = 0;
    int cycle_count = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 88;
    bit in_fired = 1'b0;

    logic [LEN_W-1:0] phase_len[NUM_PHASES] = '{7'd1, 7'd127, 7'd3, 7'd2, 7'd64, 7'd65, 7'd0};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic drop_oldest_entry();
        logic [SEG_W-1:0] gone;
        if (ring_fill != 0)
        begin
            gone = ring_ids[ring_head];
            if (gone < NUM_SEGMENTS && seg_counts[gone] > 0)
                seg_counts[gone]--;
            ring_head = (ring_head + 1) % WINDOW_DEPTH;
            ring_fill--;
        end
    endtask

    task automatic apply_word_and_select_victim(input in_word_t w, output out_word_t victim);
        int               eff;
        int               kept;
        int               r;
        int               s;
        logic [SEG_W-1:0] v;
        bit               found_any;
        bit               found_res;
        int               any_id;
        int               res_id;
        int               res_cnt;
        found_any = 1'b0;
        found_res = 1'b0;
        any_id = 0;
        res_id = 0;
        res_cnt = 0;
        if (w.segment_id < NUM_SEGMENTS)
        begin
            case (w.op)
                OP_REFERENCE:
                begin
                    if (ring_fill < WINDOW_DEPTH)
                    begin
                        ring_ids[(ring_head + ring_fill) % WINDOW_DEPTH] = w.segment_id;
                        ring_fill++;
                        if (seg_counts[w.segment_id] < COUNT_MAX)
                            seg_counts[w.segment_id]++;
                    end
                    eff = int'(window_len);
                    if (eff < 2)
                        eff = 2;
                    if (eff > WINDOW_DEPTH)
                        eff = WINDOW_DEPTH;
                    if (ring_fill >= eff)
                        drop_oldest_entry();
                end
                OP_RESIDENCY:
                    seg_resident[w.segment_id] = w.resident;
                OP_FORGET:
                begin
                    kept = 0;
                    for (r = 0; r < ring_fill; r++)
                    begin
                        v = ring_ids[(ring_head + r) % WINDOW_DEPTH];
                        if (v != w.segment_id)
                        begin
                            ring_ids[(ring_head + kept) % WINDOW_DEPTH] = v;
                            kept++;
                        end
                    end
                    ring_fill = kept;
                    seg_counts[w.segment_id] = '0;
                end
                default:
                begin
                end
            endcase
        end
        for (s = 0; s < NUM_SEGMENTS; s++)
        begin
            if (seg_counts[s] != 0)
            begin
                if (!found_any)
                begin
                    found_any = 1'b1;
                    any_id = s;
                end
                if (seg_resident[s] && (!found_res || seg_counts[s] < res_cnt))
                begin
                    found_res = 1'b1;
                    res_id = s;
                    res_cnt = int'(seg_counts[s]);
                end
            end
        end
        victim = '0;
        if (found_res)
        begin
            victim.victim_id = SEG_W'(res_id);
            victim.victim_valid = 1'b1;
            victim.victim_is_resident = 1'b1;
            victim.victim_count = CNT_W'(res_cnt);
        end
        else if (found_any)
        begin
            victim.victim_id = SEG_W'(any_id);
            victim.victim_valid = 1'b1;
            victim.victim_count = seg_counts[any_id];
        end
    endtask

    always @(posedge clk)
    begin : monitor
        out_word_t want;
        out_word_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        in_fired <= rst_n && req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            apply_word_and_select_victim(req_if.data, want);
            victims_due = {victims_due, want};
        end
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (victims_due.size() == 0)
                report_mismatch($sformatf("result word %h with no word pending", got));
            else
            begin
                want = victims_due[0];
                victims_due.delete(0);
                if (got.victim_id !== want.victim_id)
                    report_mismatch($sformatf("victim_id %0d, want %0d",
                        got.victim_id, want.victim_id));
                if (got.victim_valid !== want.victim_valid)
                    report_mismatch($sformatf("victim_valid %b, want %b",
                        got.victim_valid, want.victim_valid));
                if (got.victim_is_resident !== want.victim_is_resident)
                    report_mismatch($sformatf("victim_is_resident %b, want %b",
                        got.victim_is_resident, want.victim_is_resident));
                if (got.victim_count !== want.victim_count)
                    report_mismatch($sformatf("victim_count %0d, want %0d",
                        got.victim_count, want.victim_count));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (!req_if.valid || in_fired)
            begin
                if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_if.data <= words_to_send[0];
                    words_to_send.delete(0);
                    req_if.valid <= 1'b1;
                end
                else
                    req_if.valid <= 1'b0;
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [SEG_W-1:0] seg,
                              input logic res);
        in_word_t w;
        w.op = op;
        w.segment_id = seg;
        w.resident = res;
        words_to_send = {words_to_send, w};
    endtask

    task automatic queue_random_words(input int count);
        int               made;
        int               pick;
        int               run;
        logic [SEG_W-1:0] hot_base;
        logic [SEG_W-1:0] seg;
        made = 0;
        hot_base = SEG_W'($urandom_range(7) * 8);
        while (made < count)
        begin
            if ($urandom_range(49) == 0)
                hot_base = SEG_W'($urandom_range(7) * 8);
            pick = $urandom_range(99);
            if ($urandom_range(3) != 0)
                seg = SEG_W'(hot_base + $urandom_range(7));
            else
                seg = SEG_W'($urandom_range(63));
            if (pick < 4)
            begin
                run = $urandom_range(30, 10);
                repeat (run)
                    queue_word(OP_REFERENCE, seg, 1'($urandom_range(1)));
                made += run;
            end
            else if (pick < 58)
            begin
                queue_word(OP_REFERENCE, seg, 1'($urandom_range(1)));
                made++;
            end
            else if (pick < 83)
            begin
                queue_word(OP_RESIDENCY, seg, 1'($urandom_range(1)));
                made++;
            end
            else if (pick < 94)
            begin
                queue_word(OP_FORGET, seg, 1'($urandom_range(1)));
                made++;
            end
            else
            begin
                queue_word(OP_UNUSED, seg, 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    task automatic wait_until_idle();
        while (words_to_send.size() != 0 || req_if.valid || victims_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_if.data <= value;
        cfg_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        window_len = cfg_if.data;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        int phase;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 24;
            end
            else if (phase == 5)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window_length(phase_len[phase]);
            if (phase == 0)
            begin
                queue_word(OP_RESIDENCY, 6'd0, 1'b1);
                queue_word(OP_UNUSED, 6'd63, 1'b1);
                queue_word(OP_UNUSED, 6'd0, 1'b0);
                queue_word(OP_REFERENCE, 6'd63, 1'b0);
                queue_word(OP_REFERENCE, 6'd0, 1'b1);
                queue_word(OP_REFERENCE, 6'd0, 1'b0);
                queue_word(OP_RESIDENCY, 6'd63, 1'b1);
                queue_word(OP_REFERENCE, 6'd63, 1'b1);
                queue_word(OP_RESIDENCY, 6'd0, 1'b0);
                queue_word(OP_FORGET, 6'd63, 1'b0);
                queue_word(OP_FORGET, 6'd0, 1'b1);
                queue_word(OP_REFERENCE, 6'd42, 1'b0);
                queue_word(OP_REFERENCE, 6'd21, 1'b1);
                queue_word(OP_RESIDENCY, 6'd21, 1'b1);
                queue_word(OP_FORGET, 6'd5, 1'b0);
                queue_word(OP_FORGET, 6'd21, 1'b1);
                queue_word(OP_RESIDENCY, 6'd63, 1'b0);
                queue_word(OP_REFERENCE, 6'd63, 1'b0);
            end
            queue_random_words(WORDS_PER_PHASE);
            wait_until_idle();
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
